[rtl/core/cbpe_pkg.sv]
// Shared definitions for the cubic Bezier point evaluator.
// Field widths, fixed-point formats, register indices and reset values.
// No dependencies.
`default_nettype none

package cbpe_pkg;

  // Request and result field widths
  localparam int IDX_W   = 10;
  localparam int CNT_W   = 11;
  localparam int COORD_W = 16;
  localparam int IN_W    = 24;   // idx + cnt, padded to whole bytes
  localparam int OUT_W   = 32;

  // Curve parameter t, unsigned Q1.16
  localparam int T_W = 17;
  localparam logic [T_W-1:0] T_ONE = 17'h10000;

  // Products of two t-sized values, and the Q.48 Bernstein weights
  localparam int SQ_W  = 2 * T_W - 1;
  localparam int WGT_W = 3 * T_W - 2;
  localparam int FRAC  = 3 * (T_W - 1);
  // Weights are split for the coordinate multiply
  localparam int WLO_W = 25;

  localparam int NUM_PTS = 4;
  localparam int CFG_IDX_W = 3;

  localparam int MAX_SAMPLES_DEF = 1024;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [T_W-1:0]            tval_t;
  typedef logic [SQ_W-1:0]           sq_t;
  typedef logic [WGT_W-1:0]          wgt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_P0_X = 3'd0,
    REG_P0_Y = 3'd1,
    REG_P1_X = 3'd2,
    REG_P1_Y = 3'd3,
    REG_P2_X = 3'd4,
    REG_P2_Y = 3'd5,
    REG_P3_X = 3'd6,
    REG_P3_Y = 3'd7
  } reg_idx_t;

  // Control point values after reset
  localparam coord_t PX_RST [NUM_PTS] = '{16'shC000, 16'shE000, 16'sh2000, 16'sh4000};
  localparam coord_t PY_RST [NUM_PTS] = '{16'sh0000, 16'shE000, 16'sh2000, 16'sh0000};

endpackage

`default_nettype wire

[rtl/core/cubic_bezier_point_eval.sv]
// Cubic Bezier point evaluator, top level: control point registers and
// the parameter, weight and blend pipelines. Depends on cbpe_pkg,
// cbpe_div, cbpe_weights and cbpe_blend.
//
// Each request carries a sample index and a sample count and returns one
// point of the cubic Bezier curve set by four control points (signed
// Q2.14). The count is clamped to MAX_SAMPLES, the index to count - 1,
// and t = index / (count - 1) is taken as truncated unsigned Q1.16; a
// count below two gives the first control point. The result is the exact
// Bernstein sum, rounded to nearest (ties upward) and saturated to Q2.14.
// The block is fully pipelined: one request per clock while the output is
// not stalled. The pipeline is the division row (one cell per quotient
// bit, 17 cells) plus one input stage, four weight stages and three blend
// stages; every stage holds its request under back-pressure and empty
// stages fill in behind. Control points are written through the cfg port
// and must only change while no request is in flight.
`default_nettype none

module cubic_bezier_point_eval
  import cbpe_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)
(
  input  wire                  clk,
  input  wire                  rst,
  // request: [9:0] sample_index, [20:10] sample_count, [23:21] zero
  input  wire                  s_tvalid,
  output logic                 s_tready,
  input  wire [IN_W-1:0]       s_tdata,
  // result: [15:0] point_x, [31:16] point_y
  output logic                 m_tvalid,
  input  wire                  m_tready,
  output logic [OUT_W-1:0]     m_tdata,
  // control point writes
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [COORD_W-1:0]    cfg_data
);

  coord_t pt_x [NUM_PTS];
  coord_t pt_y [NUM_PTS];

  logic   t_valid, t_ready;
  tval_t  t_val;
  logic   w_valid, w_ready;
  wgt_t   wgt [NUM_PTS];
  coord_t point_x, point_y;

  // Control point registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NUM_PTS; j++) begin
        pt_x[j] <= PX_RST[j];
        pt_y[j] <= PY_RST[j];
      end
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_P0_X: pt_x[0] <= coord_t'(cfg_data);
        REG_P0_Y: pt_y[0] <= coord_t'(cfg_data);
        REG_P1_X: pt_x[1] <= coord_t'(cfg_data);
        REG_P1_Y: pt_y[1] <= coord_t'(cfg_data);
        REG_P2_X: pt_x[2] <= coord_t'(cfg_data);
        REG_P2_Y: pt_y[2] <= coord_t'(cfg_data);
        REG_P3_X: pt_x[3] <= coord_t'(cfg_data);
        REG_P3_Y: pt_y[3] <= coord_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // Curve parameter
  cbpe_div #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_div (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .sample_index (s_tdata[IDX_W-1:0]),
    .sample_count (s_tdata[IDX_W+CNT_W-1:IDX_W]),
    .out_valid    (t_valid),
    .out_ready    (t_ready),
    .t_out        (t_val)
  );

  // Bernstein weights
  cbpe_weights u_weights (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (t_valid),
    .in_ready  (t_ready),
    .t_in      (t_val),
    .out_valid (w_valid),
    .out_ready (w_ready),
    .w         (wgt)
  );

  // Weighted sum and output register
  cbpe_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (w_valid),
    .in_ready  (w_ready),
    .w         (wgt),
    .px        (pt_x),
    .py        (pt_y),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .point_x   (point_x),
    .point_y   (point_y)
  );

  assign m_tdata = {point_y, point_x};

endmodule

`default_nettype wire

[rtl/core/cbpe_div_cell.sv]
// One restoring-division cell: produces one quotient bit per request and
// hands the partial remainder on to the next cell. Depends on cbpe_pkg.
`default_nettype none

module cbpe_div_cell
  import cbpe_pkg::*;
#(
  parameter int DW = 10
)
(
  input  wire            clk,
  input  wire            rst,
  input  wire            valid_in,
  output logic           ready_out,
  input  wire [DW-1:0]   rem_in,
  input  wire            bit_in,
  input  wire [DW-1:0]   dvs_in,
  input  wire tval_t     quo_in,
  output logic           valid_out,
  input  wire            ready_in,
  output logic [DW-1:0]  rem_out,
  output logic [DW-1:0]  dvs_out,
  output tval_t          quo_out
);

  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        fits;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem_in, bit_in};
    diff  = trial - {1'b0, dvs_in};
    fits  = (trial >= {1'b0, dvs_in});
  end

  // Stage moves when empty or when the next cell takes its request
  assign ready_out = ~valid_out | ready_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (ready_out) begin
      valid_out <= valid_in;
    end
  end

  // Remainder stays below the divisor, so DW bits hold it
  always_ff @(posedge clk) begin
    if (ready_out) begin
      rem_out <= fits ? diff[DW-1:0] : trial[DW-1:0];
      dvs_out <= dvs_in;
      quo_out <= {quo_in[T_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

[rtl/core/cbpe_div.sv]
// Curve parameter unit: clamps index and count, then forms
// t = index * 2^16 / (count - 1) through a row of cbpe_div_cell.
// Depends on cbpe_pkg and cbpe_div_cell.
`default_nettype none

module cbpe_div
  import cbpe_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)
(
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire [IDX_W-1:0]  sample_index,
  input  wire [CNT_W-1:0]  sample_count,
  output logic             out_valid,
  input  wire              out_ready,
  output tval_t            t_out
);

  // Largest count that can matter, and the divisor width it needs
  localparam int CW  = CNT_W + 1;
  localparam int CAP = (MAX_SAMPLES < (1 << CNT_W)) ? MAX_SAMPLES : (1 << CNT_W);
  localparam int DW  = $clog2(CAP);
  localparam logic [CW-1:0] CNT_LIMIT = CW'(CAP);

  logic [CW-1:0] cnt_cl;
  logic [CW-1:0] dvs_ext;
  logic [CW-1:0] idx_cl;

  logic          p_valid;
  logic [DW-1:0] p_rem;
  logic          p_lsb;
  logic [DW-1:0] p_dvs;

  logic          vld_w [T_W+1];
  logic          rdy_w [T_W+1];
  logic [DW-1:0] rem_w [T_W+1];
  logic [DW-1:0] dvs_w [T_W+1];
  tval_t         quo_w [T_W+1];

  // Clamp count to the limit and index to the last sample.
  // Fewer than two samples: divide zero by one, giving t = 0.
  always_comb begin
    cnt_cl  = (CW'(sample_count) > CNT_LIMIT) ? CNT_LIMIT : CW'(sample_count);
    dvs_ext = cnt_cl - CW'(1);
    idx_cl  = (CW'(sample_index) > dvs_ext) ? dvs_ext : CW'(sample_index);
    if (cnt_cl < CW'(2)) begin
      idx_cl  = '0;
      dvs_ext = CW'(1);
    end
  end

  assign in_ready = ~p_valid | rdy_w[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (in_ready) begin
      p_valid <= in_valid;
    end
  end

  // Preload index/2 so the first cell's shift brings back the full index
  always_ff @(posedge clk) begin
    if (in_ready) begin
      p_rem <= idx_cl[DW:1];
      p_lsb <= idx_cl[0];
      p_dvs <= dvs_ext[DW-1:0];
    end
  end

  assign vld_w[0] = p_valid;
  assign rem_w[0] = p_rem;
  assign dvs_w[0] = p_dvs;
  assign quo_w[0] = '0;

  // One cell per quotient bit, most significant first
  for (genvar k = 0; k < T_W; k++) begin : g_cell
    cbpe_div_cell #(
      .DW (DW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (vld_w[k]),
      .ready_out (rdy_w[k]),
      .rem_in    (rem_w[k]),
      .bit_in    ((k == 0) ? p_lsb : 1'b0),
      .dvs_in    (dvs_w[k]),
      .quo_in    (quo_w[k]),
      .valid_out (vld_w[k+1]),
      .ready_in  (rdy_w[k+1]),
      .rem_out   (rem_w[k+1]),
      .dvs_out   (dvs_w[k+1]),
      .quo_out   (quo_w[k+1])
    );
  end

  assign rdy_w[T_W] = out_ready;
  assign out_valid  = vld_w[T_W];
  assign t_out      = quo_w[T_W];

endmodule

`default_nettype wire

[rtl/core/cbpe_weights.sv]
// Bernstein weight pipeline: from t builds u^3, 3u^2t, 3ut^2 and t^3
// as exact Q.48 values over four stages. Depends on cbpe_pkg.
`default_nettype none

module cbpe_weights
  import cbpe_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire tval_t  t_in,
  output logic        out_valid,
  input  wire         out_ready,
  output wgt_t        w [NUM_PTS]
);

  localparam int NS = 4;

  logic  vld [NS];
  logic  rdy [NS];

  tval_t t0, u0;
  tval_t t1, u1;
  sq_t   uu, ut, tt;
  wgt_t  c0, c1, c2, c3;

  // Stage enables, walked back from the output
  always_comb begin
    rdy[NS-1] = ~vld[NS-1] | out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = ~vld[k] | rdy[k+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NS; k++) begin
        vld[k] <= 1'b0;
      end
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // t and its complement
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      t0 <= t_in;
      u0 <= T_ONE - t_in;
    end
  end

  // Second-order products
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      uu <= SQ_W'(u0) * SQ_W'(u0);
      ut <= SQ_W'(u0) * SQ_W'(t0);
      tt <= SQ_W'(t0) * SQ_W'(t0);
      t1 <= t0;
      u1 <= u0;
    end
  end

  // Third-order products: u^3, u^2t, ut^2, t^3
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      c0 <= WGT_W'(uu) * WGT_W'(u1);
      c1 <= WGT_W'(ut) * WGT_W'(u1);
      c2 <= WGT_W'(tt) * WGT_W'(u1);
      c3 <= WGT_W'(tt) * WGT_W'(t1);
    end
  end

  // Binomial factors 1, 3, 3, 1
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      w[0] <= c0;
      w[1] <= (c1 << 1) + c1;
      w[2] <= (c2 << 1) + c2;
      w[3] <= c3;
    end
  end

endmodule

`default_nettype wire

[rtl/core/cbpe_blend.sv]
// Weighted sum of the control points: split multiply, adder stage, then
// round to nearest and saturate to Q2.14. Depends on cbpe_pkg.
`default_nettype none

module cbpe_blend
  import cbpe_pkg::*;
(
  input  wire          clk,
  input  wire          rst,
  input  wire          in_valid,
  output logic         in_ready,
  input  wire wgt_t    w [NUM_PTS],
  input  wire coord_t  px [NUM_PTS],
  input  wire coord_t  py [NUM_PTS],
  output logic         out_valid,
  input  wire          out_ready,
  output coord_t       point_x,
  output coord_t       point_y
);

  localparam int NS    = 3;
  localparam int WHI_W = WGT_W - WLO_W;
  localparam int LO_W  = WLO_W + 1 + COORD_W;
  localparam int HI_W  = WHI_W + 1 + COORD_W;
  localparam int LOS_W = LO_W + 2;
  localparam int HIS_W = HI_W + 2;
  localparam int ACC_W = HIS_W + WLO_W;
  localparam int Q_W   = ACC_W - FRAC;
  localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(1) <<< (FRAC - 1);
  localparam logic signed [Q_W-1:0]   Q_MAX = Q_W'((1 << (COORD_W - 1)) - 1);
  localparam logic signed [Q_W-1:0]   Q_MIN = -Q_MAX - Q_W'(1);

  logic vld [NS];
  logic rdy [NS];

  logic signed [WLO_W:0]     lo_op [NUM_PTS];
  logic signed [WHI_W:0]     hi_op [NUM_PTS];
  logic signed [LO_W-1:0]    lo_x  [NUM_PTS];
  logic signed [LO_W-1:0]    lo_y  [NUM_PTS];
  logic signed [HI_W-1:0]    hi_x  [NUM_PTS];
  logic signed [HI_W-1:0]    hi_y  [NUM_PTS];
  logic signed [LOS_W-1:0]   ls_x, ls_y, ls_x_next, ls_y_next;
  logic signed [HIS_W-1:0]   hs_x, hs_y, hs_x_next, hs_y_next;
  logic signed [ACC_W-1:0]   acc_x, acc_y;

  function automatic coord_t sat(input logic signed [Q_W-1:0] v);
    coord_t r;
    if (v > Q_MAX) r = coord_t'(Q_MAX);
    else if (v < Q_MIN) r = coord_t'(Q_MIN);
    else r = coord_t'(v);
    return r;
  endfunction

  always_comb begin
    rdy[NS-1] = ~vld[NS-1] | out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = ~vld[k] | rdy[k+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NS; k++) begin
        vld[k] <= 1'b0;
      end
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Weight halves as non-negative signed operands
  always_comb begin
    for (int j = 0; j < NUM_PTS; j++) begin
      lo_op[j] = $signed({1'b0, w[j][WLO_W-1:0]});
      hi_op[j] = $signed({1'b0, w[j][WGT_W-1:WLO_W]});
    end
  end

  // Partial products, one pair per control point and axis
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int j = 0; j < NUM_PTS; j++) begin
        lo_x[j] <= LO_W'(lo_op[j]) * LO_W'(px[j]);
        lo_y[j] <= LO_W'(lo_op[j]) * LO_W'(py[j]);
        hi_x[j] <= HI_W'(hi_op[j]) * HI_W'(px[j]);
        hi_y[j] <= HI_W'(hi_op[j]) * HI_W'(py[j]);
      end
    end
  end

  // Sum the low and high halves separately
  always_comb begin
    ls_x_next = '0;
    ls_y_next = '0;
    hs_x_next = '0;
    hs_y_next = '0;
    for (int j = 0; j < NUM_PTS; j++) begin
      ls_x_next = ls_x_next + LOS_W'(lo_x[j]);
      ls_y_next = ls_y_next + LOS_W'(lo_y[j]);
      hs_x_next = hs_x_next + HIS_W'(hi_x[j]);
      hs_y_next = hs_y_next + HIS_W'(hi_y[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      ls_x <= ls_x_next;
      ls_y <= ls_y_next;
      hs_x <= hs_x_next;
      hs_y <= hs_y_next;
    end
  end

  // Recombine, add half an LSB, floor by the arithmetic shift, saturate
  always_comb begin
    acc_x = (ACC_W'(hs_x) <<< WLO_W) + ACC_W'(ls_x) + HALF;
    acc_y = (ACC_W'(hs_y) <<< WLO_W) + ACC_W'(ls_y) + HALF;
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      point_x <= sat(acc_x[ACC_W-1:FRAC]);
      point_y <= sat(acc_y[ACC_W-1:FRAC]);
    end
  end

endmodule

`default_nettype wire

[bench/cubic_bezier_point_eval_tb.sv]
// Self-checking bench for cubic_bezier_point_eval: directed and random point requests,
// checked against a local Bernstein-sum predictor. Depends on cbpe_pkg and the block's RTL.
`timescale 1ns / 100ps

module cubic_bezier_point_eval_tb
  import cbpe_pkg::*;
();

  localparam int MAX_SAMPLES = MAX_SAMPLES_DEF;
  localparam int LATENCY = 25;
  localparam int SETTLE_CYCLES = 2 * LATENCY;
  localparam int CYCLE_LIMIT = 200000;
  localparam int STALL_CYCLES = 300;
  localparam logic [63:0] T_UNIT = 64'd65536;
  localparam logic [63:0] HALF_LSB = 64'd1 << 47;
  localparam logic [COORD_W-1:0] C_MAX = 16'h7FFF;
  localparam logic [COORD_W-1:0] C_MIN = 16'h8000;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [OUT_W-1:0]     m_tdata;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COORD_W-1:0]   cfg_data;

  // Bench copy of the control points
  coord_t ctrl_x [NUM_PTS];
  coord_t ctrl_y [NUM_PTS];

  point_t points_due [$];
  int     mismatches;
  int     cycle_count;
  int     send_idle_pct;
  int     recv_idle_pct;
  int     hold_left;

  cubic_bezier_point_eval #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  // Round the Q.48 biased sum to nearest, ties up, remove the bias and clamp
  function automatic coord_t round_sat(logic [63:0] acc);
    longint v;
    v = longint'((acc + HALF_LSB) >> 48) - 32768;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[COORD_W-1:0];
  endfunction

  // Expected curve point for one request
  function automatic point_t bezier_point(logic [IDX_W-1:0] idx_in, logic [CNT_W-1:0] cnt_in);
    logic [63:0] idx;
    logic [63:0] cnt;
    logic [63:0] t;
    logic [63:0] u;
    logic [63:0] acc_x;
    logic [63:0] acc_y;
    logic [63:0] w [NUM_PTS];
    point_t      pt;
    int          j;
    cnt = 64'(cnt_in);
    idx = 64'(idx_in);
    if (cnt > 64'(MAX_SAMPLES)) cnt = 64'(MAX_SAMPLES);
    t = 64'd0;
    if (cnt >= 64'd2) begin
      if (idx > cnt - 64'd1) idx = cnt - 64'd1;
      t = (idx * T_UNIT) / (cnt - 64'd1);
      if (t > T_UNIT) t = T_UNIT;
    end
    u = T_UNIT - t;
    w[0] = u * u * u;
    w[1] = 64'd3 * u * u * t;
    w[2] = 64'd3 * u * t * t;
    w[3] = t * t * t;
    acc_x = 64'd0;
    acc_y = 64'd0;
    // coordinates offset by half range so the sum stays unsigned
    for (j = 0; j < NUM_PTS; j++) begin
      acc_x += w[j] * 64'({~ctrl_x[j][COORD_W-1], ctrl_x[j][COORD_W-2:0]});
      acc_y += w[j] * 64'({~ctrl_y[j][COORD_W-1], ctrl_y[j][COORD_W-2:0]});
    end
    pt.x = round_sat(acc_x);
    pt.y = round_sat(acc_y);
    return pt;
  endfunction

  // One request: optional idle gap, then hold it until accepted
  task automatic send_request(input logic [IDX_W-1:0] idx, input logic [CNT_W-1:0] cnt);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_W - IDX_W - CNT_W){1'b0}}, cnt, idx};
    do @(posedge clk); while (!s_tready);
    points_due.push_back(bezier_point(idx, cnt));
    @(negedge clk);
  endtask

  // Mostly well-formed requests, with some noise across the full field ranges
  task automatic send_random_request();
    logic [CNT_W-1:0] cnt;
    logic [IDX_W-1:0] idx;
    if ($urandom_range(0, 9) < 7) begin
      if ($urandom_range(0, 3) == 0) cnt = CNT_W'($urandom_range(2, 8));
      else cnt = CNT_W'($urandom_range(2, MAX_SAMPLES));
      idx = IDX_W'($urandom_range(0, cnt - 1));
    end else begin
      if ($urandom_range(0, 3) == 0) cnt = CNT_W'($urandom_range(0, 1));
      else cnt = CNT_W'($urandom);
      idx = IDX_W'($urandom);
    end
    send_request(idx, cnt);
  endtask

  // Write one control point register and mirror it
  task automatic write_reg(input reg_idx_t r, input logic [COORD_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(negedge clk);
    if (r[0]) ctrl_y[r >> 1] = v;
    else ctrl_x[r >> 1] = v;
  endtask

  // All eight registers, register k in bits [16k +: 16]
  task automatic load_points(input logic [8*COORD_W-1:0] vals);
    int k;
    for (k = REG_P0_X; k <= REG_P3_Y; k++) write_reg(reg_idx_t'(k), vals[k*COORD_W +: COORD_W]);
    cfg_we <= 1'b0;
  endtask

  // Stop sending, wait for every result, then let the pipeline settle
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (points_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Idling figures change on a rising edge, the receiver reads them on the falling one
  task automatic set_idling(input int snd, input int rcv);
    @(posedge clk);
    send_idle_pct = snd;
    recv_idle_pct = rcv;
    @(negedge clk);
  endtask

  task automatic test_reset_points();
    // reset control points, special cases of count and index
    send_request(10'd0, 11'd2);
    send_request(10'd1, 11'd2);
    send_request(10'd0, 11'd0);       // count below two
    send_request(10'd700, 11'd1);     // count below two
    send_request(10'd1023, 11'd1024);
    send_request(10'd0, 11'd1024);
    send_request(10'd1, 11'd3);       // t = one half
    send_request(10'd1023, 11'd2047); // count above the limit
    send_request(10'd512, 11'd1025);  // count above the limit
    send_request(10'd9, 11'd5);       // index past the end
    send_request(10'd1023, 11'd2);    // index past the end
    send_request(10'd341, 11'd1024);
    drain_results();
  endtask

  task automatic test_register_extremes();
    int s;
    int i;
    for (s = 0; s < 3; s++) begin
      case (s)
        0: load_points({8{C_MAX}});
        1: load_points({8{C_MIN}});
        default: load_points({2{{2{C_MIN}}, {2{C_MAX}}}});
      endcase
      for (i = 0; i < 4; i++) send_request(IDX_W'(i), 11'd4);
      drain_results();
    end
  endtask

  task automatic test_random_phase(input int n, input int snd, input int rcv);
    logic [8*COORD_W-1:0] vals;
    int k;
    int i;
    set_idling(snd, rcv);
    // control points biased towards the range ends
    for (k = 0; k < 8; k++) begin
      case ($urandom_range(0, 3))
        0: vals[k*COORD_W +: COORD_W] = C_MAX;
        1: vals[k*COORD_W +: COORD_W] = C_MIN;
        default: vals[k*COORD_W +: COORD_W] = COORD_W'($urandom);
      endcase
    end
    load_points(vals);
    for (i = 0; i < n; i++) send_random_request();
    drain_results();
  endtask

  task automatic test_output_stall();
    int i;
    set_idling(0, 0);
    // receiver holds off while requests keep coming, so the input backs up
    @(posedge clk);
    hold_left = STALL_CYCLES;
    @(negedge clk);
    for (i = 0; i < 60; i++) send_random_request();
    drain_results();
  endtask

  // Receiver: random idling, or a counted hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Result check against the oldest outstanding point
  always @(posedge clk) begin
    point_t due;
    if (!rst && m_tvalid && m_tready) begin
      if (points_due.size() == 0) begin
        $error("result with no request outstanding: %h", m_tdata);
        mismatches++;
      end else begin
        due = points_due.pop_front();
        if (m_tdata[COORD_W-1:0] !== due.x) begin
          $error("point_x expected %0d actual %0d", due.x, $signed(m_tdata[COORD_W-1:0]));
          mismatches++;
        end
        if (m_tdata[2*COORD_W-1:COORD_W] !== due.y) begin
          $error("point_y expected %0d actual %0d", due.y,
                 $signed(m_tdata[2*COORD_W-1:COORD_W]));
          mismatches++;
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int k;
    clk           = 1'b0;
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    m_tready      = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_P0_X;
    cfg_data      = '0;
    mismatches    = 0;
    cycle_count   = 0;
    hold_left     = 0;
    send_idle_pct = 7;
    recv_idle_pct = 48;
    for (k = 0; k < NUM_PTS; k++) begin
      ctrl_x[k] = PX_RST[k];
      ctrl_y[k] = PY_RST[k];
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_points();
    test_register_extremes();
    test_random_phase(180, 7, 48);
    test_random_phase(180, 48, 7);
    test_output_stall();
    test_random_phase(180, 0, 0);

    if (mismatches == 0 && points_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
